>>> sv/mtt_pkg.sv
`timescale 1ns / 1ps
package mtt_pkg;

  localparam int KIND_W  = 3;
  localparam int SLOT_W  = 5;
  localparam int GEN_W   = 32;
  localparam int TIME_W  = 31;
  localparam int RKIND_W = 2;

  // request codes
  localparam logic [KIND_W-1:0] KIND_SET       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR_ALL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK      = 3'd4;

  // result codes
  localparam logic [RKIND_W-1:0] RES_SET   = 2'd0;
  localparam logic [RKIND_W-1:0] RES_QUERY = 2'd1;
  localparam logic [RKIND_W-1:0] RES_FIRE  = 2'd2;

  // one slot entry as stored in the slot ram
  typedef struct packed {
    logic              rep;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] left;
    logic [GEN_W-1:0]  gen;
  } slot_word_t;

endpackage

>>> sv/mtt_ram.sv
`timescale 1ns / 1ps
module mtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/multi_slot_timer_table_core.sv
`timescale 1ns / 1ps
// timer slot table: slot entries live in one ram with a registered read
// query, clear and set read the handle entry; clear-all acts at accept, never raising busy;
// a set with action scans active bits one a cycle and writes the lowest free one, if any;
// tick reads every slot, one a cycle; the final beat is taken at the earliest next accept
// one request at a time; busy drops at the edge that registers its last result beat, if any
// results come as one-cycle out_strobe beats; the receiver cannot stall them
// sync reset clears active and written flops at once, so no clearing pass is needed
module multi_slot_timer_table_core #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [mtt_pkg::KIND_W-1:0]    in_kind,
  input  logic [mtt_pkg::SLOT_W-1:0]    in_handle_slot,
  input  logic [mtt_pkg::GEN_W-1:0]     in_handle_generation,
  input  logic signed [31:0]            in_rate,
  input  logic                          in_repeat_req,
  input  logic                          in_action_present,
  input  logic [mtt_pkg::TIME_W-1:0]    in_delta,
  output logic                          out_strobe,
  output logic [mtt_pkg::RKIND_W-1:0]   out_result_kind,
  output logic [mtt_pkg::SLOT_W-1:0]    out_slot,
  output logic [mtt_pkg::GEN_W-1:0]     out_generation,
  output logic                          out_active,
  output logic signed [31:0]            out_remaining,
  output logic                          out_last
);
  import mtt_pkg::*;

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;  // slot index bits
  localparam int CW = $clog2(NUM_SLOTS + 1);                     // counter holds NUM_SLOTS
  localparam int WW = $bits(slot_word_t);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOOK = 3'd1;  // handle entry read is back
  localparam logic [2:0] ST_SCAN = 3'd2;  // walking active bits for a free slot
  localparam logic [2:0] ST_PICK = 3'd3;  // picked entry read is back
  localparam logic [2:0] ST_TICK = 3'd4;  // streaming all entries through

  logic [2:0]           state_r;
  logic [NUM_SLOTS-1:0] active_r;   // slot live
  logic [NUM_SLOTS-1:0] written_r;  // entry holds data, else its generation reads as zero

  // captured request
  logic [KIND_W-1:0]    kind_r;
  logic [SLOT_W-1:0]    hs_r;
  logic                 hs_ok_r;
  logic [GEN_W-1:0]     hg_r;
  logic [TIME_W-1:0]    period_r;
  logic                 rep_r;
  logic                 act_r;
  logic [TIME_W-1:0]    delta_r;

  logic [CW-1:0]        cnt_r;      // scan / tick read pointer
  logic [IW-1:0]        rd_idx_r;   // index of the entry on the ram read port
  logic                 tv_r;       // tick: read data valid this cycle

  // held fire beat, so the last one of a tick can be flagged
  logic                 pend_v_r;
  logic [IW-1:0]        pend_idx_r;
  logic [GEN_W-1:0]     pend_gen_r;

  // output beat registers
  logic                 out_strobe_r;
  logic [RKIND_W-1:0]   out_kind_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [GEN_W-1:0]     out_gen_r;
  logic                 out_active_r;
  logic [31:0]          out_rem_r;
  logic                 out_last_r;

  // ram ports
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [WW-1:0]        ram_wdata;
  logic [IW-1:0]        ram_raddr;
  logic [WW-1:0]        ram_rdata;

  mtt_ram #(
    .WIDTH (WW),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // decode of the incoming handle
  logic [8:0]  in_hs_m1;
  logic        in_hs_ok;
  logic [IW-1:0] in_idx;
  logic        accept;

  assign accept   = start && (state_r == ST_IDLE);
  assign in_hs_m1 = 9'(in_handle_slot) - 9'd1;
  assign in_hs_ok = (in_handle_slot != '0) && (9'(in_handle_slot) <= 9'(NUM_SLOTS));
  assign in_idx   = in_hs_m1[IW-1:0];

  // read data, with never-written entries seen as zero generation
  slot_word_t    rd_word;
  logic [GEN_W-1:0] rd_gen;
  logic          live;
  logic [GEN_W-1:0] gen_inc;
  logic [GEN_W-1:0] gen_nxt;

  assign rd_word = slot_word_t'(ram_rdata);
  assign rd_gen  = written_r[rd_idx_r] ? rd_word.gen : '0;
  assign live    = hs_ok_r && active_r[rd_idx_r] && (rd_gen == hg_r);
  assign gen_inc = rd_gen + 32'd1;
  assign gen_nxt = (gen_inc == '0) ? 32'd1 : gen_inc;  // generation skips zero on wrap

  // tick arithmetic for the entry on the read port
  logic              t_act;
  logic              t_fire;
  logic [TIME_W-1:0] t_sub;
  logic [TIME_W-1:0] left_nxt;

  assign t_act  = tv_r && active_r[rd_idx_r];
  assign t_fire = t_act && !(rd_word.left > delta_r);
  assign t_sub  = rd_word.left - delta_r;
  // reload is old - delta + max(period, delta), wrapped to 31 bits
  assign left_nxt = t_fire ? ((rd_word.period > delta_r) ? t_sub + rd_word.period
                                                         : rd_word.left)
                           : t_sub;

  logic scan_end;
  logic tick_end;
  logic [8:0] scan_slot;
  logic [8:0] pend_slot;

  assign scan_end  = (cnt_r == CW'(NUM_SLOTS));
  assign tick_end  = scan_end && !tv_r;
  assign scan_slot = 9'(rd_idx_r) + 9'd1;
  assign pend_slot = 9'(pend_idx_r) + 9'd1;

  // ram port control
  always_comb begin
    ram_raddr = cnt_r[IW-1:0];
    ram_we    = 1'b0;
    ram_waddr = rd_idx_r;
    ram_wdata = ram_rdata;
    if (accept) begin
      ram_raddr = in_idx;
    end
    case (state_r)
      ST_PICK: begin
        ram_we    = 1'b1;
        ram_wdata = WW'({rep_r, period_r, period_r, gen_nxt});
      end
      ST_TICK: begin
        // one-shot slots that fire only drop their active bit
        ram_we    = t_act && (!t_fire || rd_word.rep);
        ram_wdata = WW'({rd_word.rep, rd_word.period, left_nxt, rd_word.gen});
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      active_r     <= '0;
      written_r    <= '0;
      tv_r         <= 1'b0;
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_kind)
              KIND_SET, KIND_CLEAR, KIND_QUERY: state_r <= ST_LOOK;
              KIND_CLEAR_ALL:                   active_r <= '0;
              KIND_TICK: begin
                state_r  <= ST_TICK;
                tv_r     <= 1'b0;
                pend_v_r <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_LOOK: begin
          if (live && (kind_r inside {KIND_SET, KIND_CLEAR})) begin
            active_r[rd_idx_r] <= 1'b0;
          end
          if (kind_r == KIND_SET && act_r) begin
            state_r <= ST_SCAN;
          end else begin
            state_r      <= ST_IDLE;
            out_strobe_r <= (kind_r != KIND_CLEAR);
          end
        end
        ST_SCAN: begin
          if (scan_end) begin
            state_r      <= ST_IDLE;  // table full
            out_strobe_r <= 1'b1;
          end else if (!active_r[cnt_r[IW-1:0]]) begin
            state_r <= ST_PICK;
          end
        end
        ST_PICK: begin
          active_r[rd_idx_r]  <= 1'b1;
          written_r[rd_idx_r] <= 1'b1;
          out_strobe_r        <= 1'b1;
          state_r             <= ST_IDLE;
        end
        ST_TICK: begin
          tv_r <= !scan_end;
          if (t_fire) begin
            if (!rd_word.rep) begin
              active_r[rd_idx_r] <= 1'b0;
            end
            // release the held beat, hold this one
            out_strobe_r <= pend_v_r;
            pend_v_r     <= 1'b1;
          end
          if (tick_end) begin
            out_strobe_r <= pend_v_r;
            pend_v_r     <= 1'b0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= in_kind;
      hs_r     <= in_handle_slot;
      hs_ok_r  <= in_hs_ok;
      hg_r     <= in_handle_generation;
      period_r <= in_rate[31] ? '0 : in_rate[30:0];  // negative rate clamps to zero
      rep_r    <= in_repeat_req;
      act_r    <= in_action_present;
      delta_r  <= in_delta;
      cnt_r    <= '0;
      rd_idx_r <= in_idx;
    end
    case (state_r)
      ST_LOOK: begin
        out_kind_r   <= (kind_r == KIND_QUERY) ? RES_QUERY : RES_SET;
        out_slot_r   <= (kind_r == KIND_QUERY) ? hs_r : '0;
        out_gen_r    <= '0;
        out_active_r <= (kind_r == KIND_QUERY) && live;
        out_rem_r    <= (kind_r != KIND_QUERY) ? 32'd0
                      : live ? {1'b0, rd_word.left} : '1;
        out_last_r   <= 1'b0;
      end
      ST_SCAN: begin
        if (!scan_end && !active_r[cnt_r[IW-1:0]]) begin
          rd_idx_r <= cnt_r[IW-1:0];
        end else begin
          cnt_r <= cnt_r + CW'(1);
        end
        out_kind_r   <= RES_SET;
        out_slot_r   <= '0;
        out_gen_r    <= '0;
        out_active_r <= 1'b0;
        out_rem_r    <= '0;
        out_last_r   <= 1'b0;
      end
      ST_PICK: begin
        out_kind_r   <= RES_SET;
        out_slot_r   <= scan_slot[SLOT_W-1:0];
        out_gen_r    <= gen_nxt;
        out_active_r <= 1'b0;
        out_rem_r    <= '0;
        out_last_r   <= 1'b0;
      end
      ST_TICK: begin
        if (!scan_end) begin
          cnt_r    <= cnt_r + CW'(1);
          rd_idx_r <= cnt_r[IW-1:0];
        end
        if (t_fire) begin
          pend_idx_r <= rd_idx_r;
          pend_gen_r <= rd_gen;
        end
        out_kind_r   <= RES_FIRE;
        out_slot_r   <= pend_slot[SLOT_W-1:0];
        out_gen_r    <= pend_gen_r;
        out_active_r <= 1'b0;
        out_rem_r    <= '0;
        out_last_r   <= tick_end;
      end
      default: begin
      end
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_result_kind = out_kind_r;
  assign out_slot        = out_slot_r;
  assign out_generation  = out_gen_r;
  assign out_active      = out_active_r;
  assign out_remaining   = out_rem_r;
  assign out_last        = out_last_r;

endmodule

>>> bench/multi_slot_timer_table_core_test.sv
`timescale 1ns / 1ps
module multi_slot_timer_table_core_test;
  import mtt_pkg::*;

  localparam int NUM_SLOTS    = 16;
  localparam int PHASE_ITEMS  = 110;     // random requests in each of the three phases
  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES = 40;      // quiet cycles at the end, enough for a whole tick

  // one request beat, field by field as it sits on the in_ ports
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] hslot;
    logic [GEN_W-1:0]  hgen;
    logic [31:0]       rate;
    logic              rep;
    logic              act;
    logic [TIME_W-1:0] delta;
  } request_t;

  localparam int REQ_W = $bits(request_t);

  // one result beat as it sits on the out_ ports
  typedef struct packed {
    logic [RKIND_W-1:0] rkind;
    logic [SLOT_W-1:0]  slot;
    logic [GEN_W-1:0]   gen;
    logic               active;
    logic [31:0]        remaining;
    logic               last;
  } result_t;

  // shadow timer table plus the queue of result beats still owed by the block
  class timer_scoreboard;
    bit                tbl_active [NUM_SLOTS];
    bit                tbl_repeat [NUM_SLOTS];
    bit [TIME_W-1:0]   tbl_period [NUM_SLOTS];
    bit [TIME_W-1:0]   tbl_left   [NUM_SLOTS];
    bit [GEN_W-1:0]    tbl_gen    [NUM_SLOTS];
    result_t           owed_beats [$];
    int mismatches;
    int requests;
    int beats;
    int fires;
    int empty_replies;

    // table index of a live handle, or -1
    function int live_index(logic [SLOT_W-1:0] hs, logic [GEN_W-1:0] hg);
      if (hs == 0 || hs > NUM_SLOTS) return -1;
      if (tbl_active[hs-1] && tbl_gen[hs-1] == hg) return hs - 1;
      return -1;
    endfunction

    // mostly live handles, some stale, some freed, some plain garbage
    function void draw_handle(output logic [SLOT_W-1:0] hs, output logic [GEN_W-1:0] hg);
      int live [$];
      int k;
      for (k = 0; k < NUM_SLOTS; k++) if (tbl_active[k]) live.insert(live.size(), k);
      hs = SLOT_W'($urandom_range(31));
      hg = GEN_W'($urandom_range(3));
      if (live.size() > 0 && $urandom_range(9) < 7) begin
        k  = live[$urandom_range(live.size() - 1)];
        hs = SLOT_W'(k + 1);
        hg = tbl_gen[k];
        if ($urandom_range(9) == 0) hg = hg - 1;
      end else if ($urandom_range(1)) begin
        k  = $urandom_range(NUM_SLOTS - 1);
        hs = SLOT_W'(k + 1);
        hg = tbl_gen[k];
      end
    endfunction

    // accepted request: update the shadow table and queue the beats it causes
    function void note_request(request_t rq);
      int        idx;
      int        pick;
      int        k;
      result_t   r;
      result_t   fired [$];
      bit [31:0] reload;
      bit [31:0] sum;
      requests++;
      r = '0;
      case (rq.kind)
        KIND_SET: begin
          idx = live_index(rq.hslot, rq.hgen);
          if (idx >= 0) tbl_active[idx] = 1'b0;
          pick = -1;
          if (rq.act)
            for (k = 0; k < NUM_SLOTS && pick < 0; k++) if (!tbl_active[k]) pick = k;
          r.rkind = RES_SET;
          if (pick < 0) begin
            empty_replies++;
          end else begin
            // negative rate clamps to zero
            tbl_period[pick] = rq.rate[31] ? '0 : rq.rate[TIME_W-1:0];
            tbl_left[pick]   = tbl_period[pick];
            tbl_repeat[pick] = rq.rep;
            tbl_active[pick] = 1'b1;
            tbl_gen[pick]    = tbl_gen[pick] + 1;
            if (tbl_gen[pick] == 0) tbl_gen[pick] = 1;
            r.slot = SLOT_W'(pick + 1);
            r.gen  = tbl_gen[pick];
          end
          owed_beats.insert(owed_beats.size(), r);
        end
        KIND_CLEAR: begin
          idx = live_index(rq.hslot, rq.hgen);
          if (idx >= 0) tbl_active[idx] = 1'b0;
        end
        KIND_QUERY: begin
          idx = live_index(rq.hslot, rq.hgen);
          r.rkind = RES_QUERY;
          r.slot  = rq.hslot;
          if (idx >= 0) begin
            r.active    = 1'b1;
            r.remaining = {1'b0, tbl_left[idx]};
          end else begin
            r.remaining = '1;
          end
          owed_beats.insert(owed_beats.size(), r);
        end
        KIND_CLEAR_ALL: begin
          for (k = 0; k < NUM_SLOTS; k++) tbl_active[k] = 1'b0;
        end
        KIND_TICK: begin
          for (k = 0; k < NUM_SLOTS; k++) begin
            if (tbl_active[k]) begin
              if (tbl_left[k] > rq.delta) begin
                tbl_left[k] = tbl_left[k] - rq.delta;
              end else begin
                r       = '0;
                r.rkind = RES_FIRE;
                r.slot  = SLOT_W'(k + 1);
                r.gen   = tbl_gen[k];
                fired.insert(fired.size(), r);
                if (tbl_repeat[k]) begin
                  // reload max(period, delta), carrying the overshoot
                  reload = (tbl_period[k] > rq.delta) ? {1'b0, tbl_period[k]}
                                                      : {1'b0, rq.delta};
                  sum = {1'b0, tbl_left[k]} + reload - {1'b0, rq.delta};
                  tbl_left[k] = sum[TIME_W-1:0];
                end else begin
                  tbl_active[k] = 1'b0;
                end
              end
            end
          end
          if (fired.size() > 0) fired[fired.size()-1].last = 1'b1;
          fires += fired.size();
          foreach (fired[j]) owed_beats.insert(owed_beats.size(), fired[j]);
        end
        default: ;  // unused kinds are dropped
      endcase
    endfunction

    // result beat seen on the out_ ports: compare with the oldest owed beat
    function void check_beat(result_t got);
      result_t want;
      beats++;
      if (owed_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: kind %0d slot %0d gen %h act %0b rem %h last %0b",
                   got.rkind, got.slot, got.gen, got.active, got.remaining, got.last);
        return;
      end
      want = owed_beats.pop_front();
      if (got.rkind !== want.rkind || got.slot !== want.slot || got.gen !== want.gen ||
          got.active !== want.active || got.remaining !== want.remaining ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on beat %0d", beats);
          $display("  want kind %0d slot %0d gen %h act %0b rem %h last %0b",
                   want.rkind, want.slot, want.gen, want.active, want.remaining, want.last);
          $display("  got  kind %0d slot %0d gen %h act %0b rem %h last %0b",
                   got.rkind, got.slot, got.gen, got.active, got.remaining, got.last);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n                = 1'b0;
  logic                start                = 1'b0;
  logic                busy;
  logic [KIND_W-1:0]   in_kind              = '0;
  logic [SLOT_W-1:0]   in_handle_slot       = '0;
  logic [GEN_W-1:0]    in_handle_generation = '0;
  logic signed [31:0]  in_rate              = '0;
  logic                in_repeat_req        = 1'b0;
  logic                in_action_present    = 1'b0;
  logic [TIME_W-1:0]   in_delta             = '0;
  logic                out_strobe;
  logic [RKIND_W-1:0]  out_result_kind;
  logic [SLOT_W-1:0]   out_slot;
  logic [GEN_W-1:0]    out_generation;
  logic                out_active;
  logic signed [31:0]  out_remaining;
  logic                out_last;

  timer_scoreboard sb = new;
  int              idle_pct   = 0;  // chance in a hundred that the sender idles a cycle
  int              cycle_count = 0;

  multi_slot_timer_table_core #(.NUM_SLOTS(NUM_SLOTS)) uut (.*);

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // monitors: both sample pre-edge values, so no race with the block's flops
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      sb.note_request('{kind: in_kind, hslot: in_handle_slot, hgen: in_handle_generation,
                        rate: in_rate, rep: in_repeat_req, act: in_action_present,
                        delta: in_delta});
    if (rst_n && out_strobe)
      sb.check_beat('{rkind: out_result_kind, slot: out_slot, gen: out_generation,
                      active: out_active, remaining: out_remaining, last: out_last});
  end

  function automatic request_t make_request(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] hs,
                                            logic [GEN_W-1:0] hg, logic [31:0] rate,
                                            logic rep, logic act, logic [TIME_W-1:0] delta);
    make_request = '{kind: kind, hslot: hs, hgen: hg, rate: rate, rep: rep, act: act,
                     delta: delta};
  endfunction

  // present one request beat and hold it until the block takes it
  task automatic send(request_t rq);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start                <= 1'b1;
    in_kind              <= rq.kind;
    in_handle_slot       <= rq.hslot;
    in_handle_generation <= rq.hgen;
    in_rate              <= rq.rate;
    in_repeat_req        <= rq.rep;
    in_action_present    <= rq.act;
    in_delta             <= rq.delta;
    do @(posedge clk); while (busy);
  endtask

  // random period: mostly up to 0x80000 so ticks actually fire
  function automatic logic [31:0] random_rate();
    int sel;
    sel = $urandom_range(9);
    if (sel < 7) return $urandom_range(32'h0008_0000);
    if (sel == 7) return $urandom | 32'h8000_0000;  // negative, clamps to zero
    if (sel == 8) return '0;
    return $urandom;
  endfunction

  // random elapsed time, sized against the periods above
  function automatic logic [TIME_W-1:0] random_delta();
    int sel;
    sel = $urandom_range(19);
    if (sel < 12) return TIME_W'($urandom_range(32'h0004_0000));
    if (sel < 14) return '0;
    if (sel < 17) return TIME_W'($urandom_range(32'h0001_0000));
    return TIME_W'($urandom);
  endfunction

  // one random request: fully random fields, then shaped by kind
  task automatic send_random();
    request_t rq;
    int       sel;
    rq  = REQ_W'({$urandom, $urandom, $urandom, $urandom});
    sel = $urandom_range(99);
    if (sel < 34) begin
      rq.kind = KIND_SET;
      sb.draw_handle(rq.hslot, rq.hgen);
      rq.rate = random_rate();
      rq.act  = ($urandom_range(9) != 0);
    end else if (sel < 54) begin
      rq.kind  = KIND_TICK;
      rq.delta = random_delta();
    end else if (sel < 72) begin
      rq.kind = KIND_QUERY;
      sb.draw_handle(rq.hslot, rq.hgen);
    end else if (sel < 86) begin
      rq.kind = KIND_CLEAR;
      sb.draw_handle(rq.hslot, rq.hgen);
    end else if (sel < 89) begin
      rq.kind = KIND_CLEAR_ALL;
    end else if (sel < 92) begin
      rq.kind = KIND_W'($urandom_range(5, 7));
    end
    // anything above stays as pure noise across all fields
    send(rq);
  endtask

  initial begin
    int sent;
    int phase;
    int k;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: invalid handles, empty set, rate extremes, zero and full-scale ticks
    send(make_request(KIND_QUERY, 5'd0, '0, '0, 1'b0, 1'b0, '0));
    send(make_request(KIND_QUERY, 5'd31, '1, '1, 1'b1, 1'b1, '1));
    send(make_request(KIND_SET, 5'd0, '0, 32'h0005_0000, 1'b1, 1'b0, '0));
    send(make_request(KIND_SET, 5'd0, '0, 32'h8000_0000, 1'b1, 1'b1, '0));
    send(make_request(KIND_SET, 5'd0, '0, 32'h7fff_ffff, 1'b0, 1'b1, '0));
    send(make_request(KIND_SET, 5'd0, '0, 32'h0001_0000, 1'b1, 1'b1, '0));
    send(make_request(KIND_TICK, 5'd0, '0, '0, 1'b0, 1'b0, '0));
    send(make_request(KIND_QUERY, 5'd1, 32'd1, '0, 1'b0, 1'b0, '0));
    send(make_request(KIND_QUERY, 5'd2, 32'd1, '0, 1'b0, 1'b0, '0));
    send(make_request(KIND_TICK, 5'd0, '0, '0, 1'b0, 1'b0, '1));
    // set over a dead handle without action, then over a live one
    send(make_request(KIND_SET, 5'd2, 32'd1, 32'h0002_0000, 1'b0, 1'b0, '0));
    send(make_request(KIND_SET, 5'd3, 32'd1, 32'h0002_0000, 1'b0, 1'b1, '0));
    send(make_request(KIND_CLEAR, 5'd1, 32'd1, '0, 1'b0, 1'b0, '0));
    send(make_request(KIND_QUERY, 5'd1, 32'd1, '0, 1'b0, 1'b0, '0));
    send(make_request(KIND_CLEAR, 5'd0, '1, '0, 1'b0, 1'b0, '0));
    send(make_request(KIND_CLEAR, 5'd20, 32'd1, '0, 1'b0, 1'b0, '0));
    for (k = 5; k <= 7; k++)
      send(make_request(KIND_W'(k), '1, '1, '1, 1'b1, 1'b1, '1));
    send(make_request(KIND_CLEAR_ALL, 5'd0, '0, '0, 1'b0, 1'b0, '0));
    send(make_request(KIND_QUERY, 5'd2, 32'd2, '0, 1'b0, 1'b0, '0));

    // random: sender idles 29%, then 46%, then never
    sent = 0;
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 29 : (phase == 1) ? 46 : 0;
      while (sent < (phase + 1) * PHASE_ITEMS) begin
        if ($urandom_range(99) < 3) begin
          // burst of sets that runs the table full
          for (k = 0; k < NUM_SLOTS + 1; k++) begin
            send(make_request(KIND_SET, 5'd0, '0, random_rate(), 1'($urandom_range(1)),
                              1'b1, '0));
            sent++;
          end
        end else begin
          send_random();
          sent++;
        end
      end
    end
    start <= 1'b0;

    // drain: every owed beat, then DRAIN_CYCLES quiet cycles
    while (sb.owed_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests, %0d result beats, %0d fire events, %0d empty set replies",
             sb.requests, sb.beats, sb.fires, sb.empty_replies);
    $display("mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> multi_slot_timer_table_core.f
sv/mtt_pkg.sv
sv/mtt_ram.sv
sv/multi_slot_timer_table_core.sv
bench/multi_slot_timer_table_core_test.sv
